// File: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define UART_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define UART_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/core/uart_pkg.sv
package uart_pkg;

  localparam int DATA_BITS = 8;

  localparam int TICK_W = 16;
  localparam int BYTE_W = 8;
  localparam int BITS_LEFT_W = 4;
  localparam int CFG_INDEX_W = 2;

  typedef logic [TICK_W-1:0] tick_t;
  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [BITS_LEFT_W-1:0] bits_left_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;

  localparam tick_t BIT_PERIOD_RESET = tick_t'(43);
  localparam tick_t HALF_BIT_RESET = tick_t'(21);

  localparam cfg_index_t REG_BIT_PERIOD = cfg_index_t'(0);
  localparam cfg_index_t REG_HALF_BIT = cfg_index_t'(1);

  localparam bits_left_t BITS_PER_FRAME = bits_left_t'(DATA_BITS);

  // Timer reload value: a period of 0 behaves as 1.
  function automatic tick_t reload(input tick_t ticks);
    reload = (ticks == '0) ? '0 : ticks - tick_t'(1);
  endfunction

endpackage

// File: rtl/core/uart_8n1_transceiver_unit.sv
// An accepted item's result is registered straight into the output register.
// One item per cycle unless stalled; the tx and rx counters advance once per item.
// The output register frees when its result is taken, so stalls only back-pressure.
// Reset (rst_n low, synchronous): both sides idle, counters and shifters cleared,
// bit period 43 and half bit 21 ticks, output register empty.
`include "assert_macros.svh"

module uart_8n1_transceiver_unit (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  uart_pkg::cfg_index_t   cfg_index,
  input  uart_pkg::tick_t        cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_rx_line,
  input  logic                   in_send_request,
  input  uart_pkg::byte_t        in_send_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_tx_line,
  output logic                   out_tx_ready,
  output logic                   out_rx_valid,
  output uart_pkg::byte_t        out_rx_byte
);
  import uart_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  tick_t      bit_period_r, half_bit_r;

  phase_t     tx_phase_r, tx_phase_nxt;
  byte_t      tx_shift_r, tx_shift_nxt;
  bits_left_t tx_bits_left_r, tx_bits_left_nxt;
  tick_t      tx_timer_r, tx_timer_nxt;

  phase_t     rx_phase_r, rx_phase_nxt;
  byte_t      rx_shift_r, rx_shift_nxt;
  bits_left_t rx_bits_left_r, rx_bits_left_nxt;
  tick_t      rx_timer_r, rx_timer_nxt;

  logic       out_valid_r;
  logic       tx_line_r, tx_line_nxt;
  logic       tx_ready_r;
  logic       rx_valid_r, rx_valid_nxt;
  byte_t      rx_byte_r, rx_byte_nxt;

  logic       accept;
  bits_left_t tx_bits_dec, rx_bits_dec;

  assign in_stall = out_valid_r & out_stall;
  assign accept = in_valid & ~in_stall;

  assign tx_bits_dec = tx_bits_left_r - bits_left_t'(1);
  assign rx_bits_dec = rx_bits_left_r - bits_left_t'(1);

  // Transmitter
  always_comb begin
    tx_phase_nxt = tx_phase_r;
    tx_shift_nxt = tx_shift_r;
    tx_bits_left_nxt = tx_bits_left_r;
    tx_timer_nxt = tx_timer_r;
    if (tx_phase_r == PH_IDLE) begin
      if (in_send_request) begin
        tx_shift_nxt = in_send_byte;
        tx_phase_nxt = PH_START;
        tx_timer_nxt = reload(bit_period_r);
      end
    end else if (tx_timer_r != '0) begin
      tx_timer_nxt = tx_timer_r - tick_t'(1);
    end else begin
      tx_timer_nxt = reload(bit_period_r);
      case (tx_phase_r)
        PH_START: begin
          tx_phase_nxt = PH_DATA;
          tx_bits_left_nxt = BITS_PER_FRAME;
        end
        PH_DATA: begin
          tx_shift_nxt = tx_shift_r >> 1;
          tx_bits_left_nxt = tx_bits_dec;
          if (tx_bits_dec == '0) tx_phase_nxt = PH_STOP;
        end
        default: begin
          tx_phase_nxt = PH_IDLE;
          tx_timer_nxt = '0;
        end
      endcase
    end

    case (tx_phase_nxt)
      PH_START: tx_line_nxt = 1'b0;
      PH_DATA:  tx_line_nxt = tx_shift_nxt[0];
      default:  tx_line_nxt = 1'b1;
    endcase
  end

  // Receiver; start detection is on level, not on an edge of the sample
  always_comb begin
    rx_phase_nxt = rx_phase_r;
    rx_shift_nxt = rx_shift_r;
    rx_bits_left_nxt = rx_bits_left_r;
    rx_timer_nxt = rx_timer_r;
    rx_valid_nxt = 1'b0;
    rx_byte_nxt = '0;
    if (rx_phase_r == PH_IDLE) begin
      if (!in_rx_line) begin
        rx_phase_nxt = PH_START;
        rx_shift_nxt = '0;
        rx_timer_nxt = reload(half_bit_r);
      end
    end else if (rx_timer_r != '0) begin
      rx_timer_nxt = rx_timer_r - tick_t'(1);
    end else begin
      case (rx_phase_r)
        PH_START: begin
          if (in_rx_line) begin
            rx_phase_nxt = PH_IDLE;   // false start
          end else begin
            rx_phase_nxt = PH_DATA;
            rx_bits_left_nxt = BITS_PER_FRAME;
            rx_timer_nxt = reload(bit_period_r);
          end
        end
        PH_DATA: begin
          rx_shift_nxt = (rx_shift_r >> 1) | (byte_t'(in_rx_line) << (DATA_BITS - 1));
          rx_bits_left_nxt = rx_bits_dec;
          rx_timer_nxt = reload(bit_period_r);
          if (rx_bits_dec == '0) rx_phase_nxt = PH_STOP;
        end
        default: begin
          // stop bit is not checked
          rx_valid_nxt = 1'b1;
          rx_byte_nxt = rx_shift_r;
          rx_phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= BIT_PERIOD_RESET;
      half_bit_r <= HALF_BIT_RESET;
      tx_phase_r <= PH_IDLE;
      tx_shift_r <= '0;
      tx_bits_left_r <= '0;
      tx_timer_r <= '0;
      rx_phase_r <= PH_IDLE;
      rx_shift_r <= '0;
      rx_bits_left_r <= '0;
      rx_timer_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BIT_PERIOD: bit_period_r <= cfg_wdata;
          REG_HALF_BIT:   half_bit_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (accept) begin
        tx_phase_r <= tx_phase_nxt;
        tx_shift_r <= tx_shift_nxt;
        tx_bits_left_r <= tx_bits_left_nxt;
        tx_timer_r <= tx_timer_nxt;
        rx_phase_r <= rx_phase_nxt;
        rx_shift_r <= rx_shift_nxt;
        rx_bits_left_r <= rx_bits_left_nxt;
        rx_timer_r <= rx_timer_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload; loads only with an accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      tx_line_r <= tx_line_nxt;
      tx_ready_r <= (tx_phase_nxt == PH_IDLE);
      rx_valid_r <= rx_valid_nxt;
      rx_byte_r <= rx_byte_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_tx_line = tx_line_r;
  assign out_tx_ready = tx_ready_r;
  assign out_rx_valid = rx_valid_r;
  assign out_rx_byte = rx_byte_r;

  `UART_ASSERT(a_ready_line_high, (out_valid_r && tx_ready_r) |-> tx_line_r, "idle tx line low")
  `UART_ASSERT(a_byte_zero, (out_valid_r && !rx_valid_r) |-> (rx_byte_r == '0), "stray rx byte")
  `UART_ASSERT_ALWAYS(a_tx_idle_timer, (tx_phase_r == PH_IDLE) |-> (tx_timer_r == '0), "tx timer")
  `UART_ASSERT(a_accept_loads, accept |=> out_valid_r, "accepted item produced no result")
  `UART_ASSERT(a_rx_bits_range, rx_bits_left_r <= BITS_PER_FRAME, "rx bit count out of range")

endmodule
